>>> design/crcp_pkg.sv
// Shared types, widths and arithmetic helpers for the Catmull-Rom curve sampler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package crcp_pkg;

    localparam int COORD_W        = 16;
    localparam int FUNC_W         = 2;
    localparam int SEG_POINTS_DEF = 30;
    localparam int WIN_DEPTH      = 3;
    localparam int FILL_W         = 2;
    localparam int AXES           = 2;
    localparam int FIFO_DEPTH     = 2;

    // Coefficient widths, sized for segment lengths up to 65 samples.
    localparam int B_W   = 17;
    localparam int C_W   = 20;
    localparam int DEL_W = 30;
    localparam int QW    = 32;
    localparam int REM_W = 20;

    localparam logic [FUNC_W-1:0] FUNC_CURVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

    // One queued command: a pass-through point or a full four-point curve window.
    typedef struct packed {
        logic                     curve;
        logic                     new_path;
        logic [3:0][COORD_W-1:0]  px;
        logic [3:0][COORD_W-1:0]  py;
    } t_cmd;

    // Value held as quotient and remainder against the segment denominator.
    typedef struct packed {
        logic signed [QW-1:0] q;
        logic [REM_W-1:0]     r;
    } t_qr;

    function automatic t_qr qr_add(input t_qr a, input t_qr b, input logic [REM_W-1:0] m);
        t_qr              s;
        logic [REM_W-1:0] rs;
        logic             cy;
        rs  = a.r + b.r;
        cy  = (rs >= m);
        s.r = cy ? (rs - m) : rs;
        s.q = a.q + b.q + QW'(cy);
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [QW-1:0] v);
        logic [COORD_W-1:0] res;
        if (v[QW-1:COORD_W-1] == {(QW-COORD_W+1){v[QW-1]}}) begin
            res = v[COORD_W-1:0];
        end else if (v[QW-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> design/crcp_fifo.sv
// Two-entry command queue between the front classifier and the sample engine.
// Depends on crcp_pkg for the command type and depth.
`timescale 1ns / 1ps

module crcp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crcp_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output crcp_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import crcp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/crcp_front.sv
// Input classifier: keeps the window of curve control points and queues commands.
// Depends on crcp_pkg; feeds crcp_fifo.
`timescale 1ns / 1ps

module crcp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [crcp_pkg::FUNC_W-1:0]   i_func,
    input  logic [crcp_pkg::COORD_W-1:0]  i_x,
    input  logic [crcp_pkg::COORD_W-1:0]  i_y,
    input  logic                          i_full,
    output logic                          o_push,
    output crcp_pkg::t_cmd                o_cmd
);
    import crcp_pkg::*;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

    logic [COORD_W-1:0] r_win_x [WIN_DEPTH];
    logic [COORD_W-1:0] r_win_y [WIN_DEPTH];
    logic [FILL_W-1:0]  r_fill;

    logic accept;
    logic is_pass;
    logic is_curve;
    logic win_full;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_pass    = (i_func == FUNC_LINE) || (i_func == FUNC_START);
    assign is_curve   = (i_func == FUNC_CURVE);
    assign win_full   = (r_fill == FILL_FULL);

    assign o_push          = accept && (is_pass || (is_curve && win_full));
    assign o_cmd.curve     = is_curve;
    assign o_cmd.new_path  = (i_func == FUNC_START);
    assign o_cmd.px        = {i_x, r_win_x[2], r_win_x[1], r_win_x[0]};
    assign o_cmd.py        = {i_y, r_win_y[2], r_win_y[1], r_win_y[0]};

    // Window contents: store while filling, slide once full.
    always_ff @(posedge i_clk) begin
        if (accept && is_curve) begin
            if (win_full) begin
                r_win_x[0] <= r_win_x[1];
                r_win_y[0] <= r_win_y[1];
                r_win_x[1] <= r_win_x[2];
                r_win_y[1] <= r_win_y[2];
                r_win_x[2] <= i_x;
                r_win_y[2] <= i_y;
            end else begin
                r_win_x[r_fill] <= i_x;
                r_win_y[r_fill] <= i_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            unique case (i_func) inside
                FUNC_LINE, FUNC_START: begin
                    r_fill <= '0;
                end
                FUNC_CURVE: begin
                    if (!win_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> design/crcp_div.sv
// Fixed-divisor divider: reciprocal multiply, back-multiply and one correction step.
// Returns floor quotient and non-negative remainder once the fix phase ends and o_busy falls; depends on crcp_pkg.
`timescale 1ns / 1ps

module crcp_div #(
    parameter int DIVISOR = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [crcp_pkg::DEL_W-1:0]  i_num,
    output logic                               o_busy,
    output logic signed [crcp_pkg::QW-1:0]     o_quo,
    output logic [crcp_pkg::REM_W-1:0]         o_rem
);
    import crcp_pkg::*;

    localparam int               PROD_W  = 2 * DEL_W;
    localparam int               BACK_W  = DEL_W + REM_W;
    // Reciprocal truncated toward zero: the estimate is the quotient or one below it.
    localparam longint           RECIP_L = (longint'(1) << DEL_W) / longint'(DIVISOR);
    localparam logic [DEL_W-1:0] RECIP   = DEL_W'(RECIP_L);
    localparam logic [REM_W-1:0] M_V     = REM_W'(DIVISOR);

    localparam logic [1:0] PH_MUL  = 2'd0;
    localparam logic [1:0] PH_BACK = 2'd1;
    localparam logic [1:0] PH_FIX  = 2'd2;

    logic               r_busy;
    logic [1:0]         r_phase;
    logic               r_neg;
    logic [DEL_W-1:0]   r_mag;
    logic [DEL_W-1:0]   r_quo;
    logic [REM_W-1:0]   r_rem;

    logic [PROD_W-1:0]    recip_prod;
    logic [BACK_W-1:0]    back_prod;
    logic [BACK_W-1:0]    back_diff;
    logic signed [QW-1:0] quo_mag;

    assign recip_prod = {{DEL_W{1'b0}}, r_mag} * {{DEL_W{1'b0}}, RECIP};
    assign back_prod  = {{REM_W{1'b0}}, r_quo} * {{DEL_W{1'b0}}, M_V};
    assign back_diff  = {{REM_W{1'b0}}, r_mag} - back_prod;
    assign o_busy     = r_busy;
    assign quo_mag    = $signed(QW'(r_quo));

    always_comb begin
        if (r_neg && (r_rem != '0)) begin
            o_quo = ~quo_mag;
            o_rem = M_V - r_rem;
        end else if (r_neg) begin
            o_quo = -quo_mag;
            o_rem = r_rem;
        end else begin
            o_quo = quo_mag;
            o_rem = r_rem;
        end
    end

    // Estimate, then back-multiply for the remainder (below twice the divisor),
    // then fold the remainder once.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DEL_W-1];
            r_mag <= i_num[DEL_W-1] ? DEL_W'(-i_num) : DEL_W'(i_num);
        end else if (r_busy) begin
            unique case (r_phase)
                PH_MUL: begin
                    r_quo <= recip_prod[PROD_W-1:DEL_W];
                end
                PH_BACK: begin
                    r_rem <= back_diff[REM_W-1:0];
                end
                PH_FIX: begin
                    if (r_rem >= M_V) begin
                        r_quo <= r_quo + 1'b1;
                        r_rem <= r_rem - M_V;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_MUL;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= PH_MUL;
        end else if (r_busy) begin
            unique case (r_phase)
                PH_MUL: begin
                    r_phase <= PH_BACK;
                end
                PH_BACK: begin
                    r_phase <= PH_FIX;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_phase <= PH_MUL;
                end
            endcase
        end
    end

endmodule

>>> design/crcp_back.sv
// Sample engine: sets up forward differences per segment, divides them once,
// then steps the cubic one sample per beat. Depends on crcp_pkg and crcp_div.
`timescale 1ns / 1ps

module crcp_back #(
    parameter int SEGMENT_POINTS = crcp_pkg::SEG_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  crcp_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2*crcp_pkg::COORD_W-1:0]  o_data,
    output logic                            o_new_path,
    output logic                            o_last
);
    import crcp_pkg::*;

    localparam int D     = SEGMENT_POINTS - 1;
    localparam int D2    = D * D;
    localparam int D3    = D2 * D;
    localparam int M     = 2 * D3;
    localparam int CNT_W = $clog2(SEGMENT_POINTS);
    localparam logic [REM_W-1:0] M_V    = REM_W'(M);
    localparam logic [REM_W-1:0] D3_V   = REM_W'(D3);
    localparam logic [CNT_W-1:0] I_LAST = CNT_W'(D);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PASS  = 3'd1;
    localparam logic [2:0] ST_COEF  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_START = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_idx;

    wire [AXES-1:0]              axis_busy;
    wire [AXES-1:0][COORD_W-1:0] sample;
    logic                        div_done;
    logic                        step;

    assign div_done = (r_state == ST_DIV) && (axis_busy == '0);
    assign step     = (r_state == ST_EMIT) && i_ready;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        logic [3:0][COORD_W-1:0] pts;
        logic signed [COORD_W-1:0] p0, p1, p2, p3;
        logic signed [C_W-1:0]     e0, e1, e2, e3;
        logic signed [B_W-1:0]     r_b;
        logic signed [C_W-1:0]     r_c;
        logic signed [C_W-1:0]     r_d;
        logic signed [DEL_W-1:0]   r_bd2, r_cd, r_d6;
        logic signed [DEL_W-1:0]   r_del1, r_del2, r_del3;
        t_qr                       r_n, r_s1, r_s2, r_s3;
        logic signed [QW-1:0]      q1, q2, q3;
        logic [REM_W-1:0]          m1, m2, m3;
        logic                      b1, b2, b3;

        assign pts = (g == 0) ? r_cmd.px : r_cmd.py;
        assign p0  = $signed(pts[0]);
        assign p1  = $signed(pts[1]);
        assign p2  = $signed(pts[2]);
        assign p3  = $signed(pts[3]);
        assign e0  = C_W'(p0);
        assign e1  = C_W'(p1);
        assign e2  = C_W'(p2);
        assign e3  = C_W'(p3);

        always_ff @(posedge i_clk) begin
            if (r_state == ST_COEF) begin
                r_b   <= B_W'(p2) - B_W'(p0);
                r_c   <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
                r_d   <= ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
                r_n.q <= QW'(p1);
                r_n.r <= D3_V;
            end
            if (r_state == ST_MUL) begin
                r_bd2 <= DEL_W'(DEL_W'(r_b) * $signed(DEL_W'(D2)));
                r_cd  <= DEL_W'(DEL_W'(r_c) * $signed(DEL_W'(D)));
                r_d6  <= (DEL_W'(r_d) <<< 2) + (DEL_W'(r_d) <<< 1);
            end
            if (r_state == ST_SUM) begin
                r_del1 <= r_bd2 + r_cd + DEL_W'(r_d);
                r_del2 <= (r_cd <<< 1) + r_d6;
                r_del3 <= r_d6;
            end
            if (div_done) begin
                r_s1.q <= q1;
                r_s1.r <= m1;
                r_s2.q <= q2;
                r_s2.r <= m2;
                r_s3.q <= q3;
                r_s3.r <= m3;
            end
            if (step) begin
                r_n  <= qr_add(r_n, r_s1, M_V);
                r_s1 <= qr_add(r_s1, r_s2, M_V);
                r_s2 <= qr_add(r_s2, r_s3, M_V);
            end
        end

        crcp_div #(.DIVISOR(M)) u_div1 (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(r_state == ST_START),
            .i_num  (r_del1),
            .o_busy (b1),
            .o_quo  (q1),
            .o_rem  (m1)
        );

        crcp_div #(.DIVISOR(M)) u_div2 (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(r_state == ST_START),
            .i_num  (r_del2),
            .o_busy (b2),
            .o_quo  (q2),
            .o_rem  (m2)
        );

        crcp_div #(.DIVISOR(M)) u_div3 (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(r_state == ST_START),
            .i_num  (r_del3),
            .o_busy (b3),
            .o_quo  (q3),
            .o_rem  (m3)
        );

        assign axis_busy[g] = b1 || b2 || b3;
        assign sample[g]    = sat_coord(r_n.q);
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_state = i_cmd.curve ? ST_COEF : ST_PASS;
                end
            end
            ST_PASS: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_COEF:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_ready && (r_idx == I_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (div_done) begin
            r_idx <= '0;
        end else if (step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    assign o_valid    = (r_state == ST_PASS) || (r_state == ST_EMIT);
    assign o_data     = (r_state == ST_PASS) ? {r_cmd.py[3], r_cmd.px[3]}
                                             : {sample[1], sample[0]};
    assign o_new_path = (r_state == ST_PASS) && r_cmd.new_path;
    assign o_last     = (r_state == ST_PASS) || (r_idx == I_LAST);

endmodule

>>> design/catmull_rom_curve_points.sv
// Top level of the Catmull-Rom curve sampler: front classifier, command queue
// and sample engine. Depends on crcp_pkg, crcp_front, crcp_fifo and crcp_back.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   s_axis_tvalid/tready    tdata {in_y, in_x}, tuser func
// m_axis   out  m_axis_tvalid/tready    tdata {out_y, out_x}, tuser new_path, tlast last
//
// Flow: a line or start point is queued, popped and sent out from the pass state; a curve point
// that lands in a window still filling, or an unused func code, is taken by the
// front and makes no beat. A curve point on a full window goes through the sample
// engine in order: it takes the command, runs the COEF, MUL, SUM and START setup
// states, waits while the reciprocal dividers run their three steps and the step
// values load, then emits one sample per beat, holding while m_axis_tready is low.
// Reset is synchronous and active low; it empties the queue and the window.
// The front keeps taking beats while the queue has room, so a stalled m_axis
// side only stops s_axis once two commands are waiting.
`timescale 1ns / 1ps

module catmull_rom_curve_points #(
    parameter int SEGMENT_POINTS = crcp_pkg::SEG_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [2*crcp_pkg::COORD_W-1:0]  s_axis_tdata,   // in_x, in_y
    input  logic [crcp_pkg::FUNC_W-1:0]     s_axis_tuser,   // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [2*crcp_pkg::COORD_W-1:0]  m_axis_tdata,   // out_x, out_y
    output logic                            m_axis_tuser,   // new_path
    output logic                            m_axis_tlast
);
    import crcp_pkg::*;

    logic full;
    logic push;
    logic cmd_valid;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Classify input beats and hold the control-point window.
    crcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_func    (s_axis_tuser),
        .i_x       (s_axis_tdata[COORD_W-1:0]),
        .i_y       (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // Decouple classification from sample generation.
    crcp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .o_valid(cmd_valid),
        .o_cmd  (head_cmd),
        .i_pop  (pop)
    );

    // Pass points through or walk the segment one sample per beat.
    crcp_back #(.SEGMENT_POINTS(SEGMENT_POINTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_new_path (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule

>>> design/crcp_checker.sv
// Port-level checks for the Catmull-Rom curve sampler, bound to the top level.
// Depends on crcp_pkg for port widths.
`timescale 1ns / 1ps

module crcp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [2*crcp_pkg::COORD_W-1:0]  s_axis_tdata,
    input logic [crcp_pkg::FUNC_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [2*crcp_pkg::COORD_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);
    // Hold a stalled output beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // A start point is a single-beat result.
    a_start_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("start point without tlast");

    // Curve samples follow each other without gaps and never flag a new path.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && !m_axis_tuser)
        else $error("gap or new path inside a curve sample run");

endmodule

bind catmull_rom_curve_points crcp_checker u_crcp_checker (.*);
